@@ design/msa_pkg.sv @@
// Shared constants, types and state codes for the moving average block.
package msa_pkg;

    localparam int PERIOD_MAX  = 64;
    localparam int PRICE_WIDTH = 32;
    localparam int FRAC_W      = 16;
    localparam int WL_W        = 7;

    // Period, bar count and the alpha divisor (period + 1).
    localparam int PER_W   = $clog2(PERIOD_MAX + 2);
    localparam int SLOT_W  = $clog2(PERIOD_MAX);
    // Sum of up to PERIOD_MAX prices.
    localparam int SUM_W   = PRICE_WIDTH + SLOT_W;
    localparam int AVG_W   = PRICE_WIDTH + FRAC_W;
    // SMA dividend, sum scaled to Q.16.
    localparam int NUM_W   = SUM_W + FRAC_W;
    // Width of the shared adder and of the EMA accumulator.
    localparam int ACC_W   = AVG_W + FRAC_W;
    localparam int ALPHA_W = FRAC_W + 1;
    localparam int ANUM_W  = FRAC_W + 2;
    localparam int REM_W   = PER_W + 1;
    localparam int STEP_W  = $clog2(NUM_W + 1);

    localparam logic [ANUM_W-1:0]  ALPHA_NUM = {2'b10, {FRAC_W{1'b0}}};
    localparam logic [ALPHA_W-1:0] Q_ONE     = {1'b1, {FRAC_W{1'b0}}};

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

    localparam logic METHOD_SMA = 1'b0;
    localparam logic METHOD_EMA = 1'b1;

    localparam logic [WL_W-1:0] WL_RESET = 7'd14;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_SUM  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_MULA = 7'b0010000,
        S_MULB = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    typedef struct packed {
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             carry;
    } t_alu_rsp;

endpackage

@@ design/msa_addsub.sv @@
// Shared add/subtract unit used for summing, dividing and multiplying.
module msa_addsub (
    input  msa_pkg::t_alu_req i_req,
    output msa_pkg::t_alu_rsp o_rsp
);

    logic [msa_pkg::ACC_W:0] w_full;
    logic [msa_pkg::ACC_W-1:0] w_b;

    // Subtract as a plus inverted b plus one; carry high means a >= b.
    assign w_b    = i_req.sub ? ~i_req.b : i_req.b;
    assign w_full = {1'b0, i_req.a} + {1'b0, w_b}
                  + {{msa_pkg::ACC_W{1'b0}}, i_req.sub};

    assign o_rsp.sum   = w_full[msa_pkg::ACC_W-1:0];
    assign o_rsp.carry = w_full[msa_pkg::ACC_W];

endmodule

@@ design/msa_ring.sv @@
// Ring buffer of closed bar prices, one write and one registered read port.
module msa_ring (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [msa_pkg::SLOT_W-1:0]          i_waddr,
    input  logic [msa_pkg::PRICE_WIDTH-1:0]     i_wdata,
    input  logic [msa_pkg::SLOT_W-1:0]          i_raddr,
    output logic [msa_pkg::PRICE_WIDTH-1:0]     o_rdata
);

    logic [msa_pkg::PRICE_WIDTH-1:0] r_mem [msa_pkg::PERIOD_MAX];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ design/moving_average_sma_ema.sv @@
// Top level: SMA/EMA moving average over a bar price series, iterative datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one price beat: a 32-bit
//   price and a new_bar flag that opens a new bar or revises the current one.
//   Output channel (o_out_valid / i_out_stall) returns one beat per input:
//   the Q32.16 average (truncated) and valid_res, set once window_length bars
//   (clamped to 1..64) exist; average is zero while valid_res is low.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 selects
//   the method (0 SMA, 1 EMA), index 1 sets window_length. Write only while idle.
// Sequencing (one item at a time; the input stalls until the sequencer is idle):
//   not yet valid: zero result straight from PREP; EMA: 18-step divide for alpha,
//   then two 17-step shift-add multiplies; SMA: sum the current price and the
//   p - 1 older closes from the ring (no ring read for period one), then a
//   54-step restoring divide.
//   All summing, divide and multiply steps go through one shared 64-bit adder,
//   one step per cycle, and the ring memory gives one price per cycle.
// Reset (synchronous, active low): clear bar history, averages and config to
//   SMA with window 14. The first beat after reset always opens a bar.
// Output stall: the finished result waits in the output register; a new beat
//   is accepted meanwhile, but its result holds in the sequencer until taken.
module moving_average_sma_ema (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [msa_pkg::PRICE_WIDTH-1:0]     i_price,
    input  logic                                i_new_bar,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [msa_pkg::AVG_W-1:0]           o_average,
    output logic                                o_valid_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [msa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [msa_pkg::WL_W-1:0]            i_cfg_data
);

    localparam int PER_W   = msa_pkg::PER_W;
    localparam int SLOT_W  = msa_pkg::SLOT_W;
    localparam int PW      = msa_pkg::PRICE_WIDTH;
    localparam int FRAC_W  = msa_pkg::FRAC_W;
    localparam int SUM_W   = msa_pkg::SUM_W;
    localparam int AVG_W   = msa_pkg::AVG_W;
    localparam int NUM_W   = msa_pkg::NUM_W;
    localparam int ACC_W   = msa_pkg::ACC_W;
    localparam int ALPHA_W = msa_pkg::ALPHA_W;
    localparam int ANUM_W  = msa_pkg::ANUM_W;
    localparam int REM_W   = msa_pkg::REM_W;
    localparam int STEP_W  = msa_pkg::STEP_W;

    // Config registers
    logic                    r_method;
    logic [msa_pkg::WL_W-1:0] r_wl;

    // Sequencer and bar state
    msa_pkg::t_state         r_state, n_state;
    logic [PER_W-1:0]        r_bar_cnt, n_bar_cnt;
    logic [SLOT_W-1:0]       r_wslot, n_wslot;
    logic [PW-1:0]           r_cur_price, n_cur_price;
    logic [PW-1:0]           r_last_price, n_last_price;
    logic [AVG_W-1:0]        r_ema_cur, n_ema_cur;
    logic [AVG_W-1:0]        r_ema_prev, n_ema_prev;
    logic [PER_W-1:0]        r_p, n_p;
    logic                    r_meth_q, n_meth_q;

    // Datapath registers
    logic [ACC_W-1:0]        r_acc, n_acc;
    logic [NUM_W-1:0]        r_num, n_num;
    logic [REM_W-1:0]        r_rem, n_rem;
    logic [PER_W-1:0]        r_div, n_div;
    logic [STEP_W-1:0]       r_cnt, n_cnt;
    logic [ACC_W-1:0]        r_mcand, n_mcand;
    logic [ALPHA_W-1:0]      r_mult, n_mult;
    logic [ALPHA_W-1:0]      r_alpha, n_alpha;
    logic [PER_W-1:0]        r_k, n_k;
    logic [SLOT_W-1:0]       r_rptr, n_rptr;
    logic                    r_rd_pend, n_rd_pend;
    logic                    r_ema_div, n_ema_div;
    logic [AVG_W-1:0]        r_res, n_res;
    logic                    r_res_valid, n_res_valid;

    // Output register
    logic                    r_out_valid, n_out_valid;
    logic [AVG_W-1:0]        r_avg, n_avg;
    logic                    r_vres, n_vres;

    logic                    w_in_acc;
    logic                    w_open;
    logic [PER_W-1:0]        w_period;
    logic                    w_we;
    logic [PW-1:0]           w_rdata;
    logic [REM_W-1:0]        w_rem_sh;
    logic [NUM_W-1:0]        w_quot;
    logic [ACC_W-1:0]        w_mul_acc;
    logic [ACC_W-1:0]        w_base;
    logic [SLOT_W-1:0]       w_wslot_inc;
    logic [SLOT_W-1:0]       w_wslot_dec;
    logic [SLOT_W-1:0]       w_rptr_dec;
    logic                    w_issue;
    msa_pkg::t_alu_req       w_alu_req;
    msa_pkg::t_alu_rsp       w_alu_rsp;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != msa_pkg::S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_open      = i_new_bar || (r_bar_cnt == '0);
    // Push the closing bar into the ring when a bar opens over an existing one
    assign w_we        = w_in_acc && w_open && (r_bar_cnt != '0);

    assign o_out_valid = r_out_valid;
    assign o_average   = r_avg;
    assign o_valid_res = r_vres;

    // Clamp window_length into 1..PERIOD_MAX
    always_comb begin
        if (r_wl == '0) begin
            w_period = PER_W'(1);
        end else if (int'(r_wl) > msa_pkg::PERIOD_MAX) begin
            w_period = PER_W'(msa_pkg::PERIOD_MAX);
        end else begin
            w_period = PER_W'(r_wl);
        end
    end

    assign w_wslot_inc = (r_wslot == SLOT_W'(msa_pkg::PERIOD_MAX - 1)) ? '0
                       : r_wslot + SLOT_W'(1);
    assign w_wslot_dec = (r_wslot == '0) ? SLOT_W'(msa_pkg::PERIOD_MAX - 1)
                       : r_wslot - SLOT_W'(1);
    assign w_rptr_dec  = (r_rptr == '0) ? SLOT_W'(msa_pkg::PERIOD_MAX - 1)
                       : r_rptr - SLOT_W'(1);

    // Restoring divide: shift in the next dividend bit, quotient bit is the carry
    assign w_rem_sh  = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
    assign w_quot    = {r_num[NUM_W-2:0], w_alu_rsp.carry};
    assign w_mul_acc = r_mult[0] ? w_alu_rsp.sum : r_acc;
    assign w_issue   = (r_k < r_p);

    // EMA base: own price on the first bar, last close when the previous EMA is zero
    always_comb begin
        if (r_bar_cnt <= PER_W'(1)) begin
            w_base = ACC_W'(r_cur_price) << FRAC_W;
        end else if (r_ema_prev == '0) begin
            w_base = ACC_W'(r_last_price) << FRAC_W;
        end else begin
            w_base = ACC_W'(r_ema_prev);
        end
    end

    // Operand select for the shared adder
    always_comb begin
        w_alu_req.a   = r_acc;
        w_alu_req.b   = r_mcand;
        w_alu_req.sub = 1'b0;
        case (r_state)
            msa_pkg::S_SUM: begin
                w_alu_req.b = ACC_W'(w_rdata);
            end
            msa_pkg::S_DIV: begin
                w_alu_req.a   = ACC_W'(w_rem_sh);
                w_alu_req.b   = ACC_W'(r_div);
                w_alu_req.sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    msa_addsub u_addsub (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    msa_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wslot),
        .i_wdata (r_cur_price),
        .i_raddr (r_rptr),
        .o_rdata (w_rdata)
    );

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_bar_cnt    = r_bar_cnt;
        n_wslot      = r_wslot;
        n_cur_price  = r_cur_price;
        n_last_price = r_last_price;
        n_ema_cur    = r_ema_cur;
        n_ema_prev   = r_ema_prev;
        n_p          = r_p;
        n_meth_q     = r_meth_q;
        n_acc        = r_acc;
        n_num        = r_num;
        n_rem        = r_rem;
        n_div        = r_div;
        n_cnt        = r_cnt;
        n_mcand      = r_mcand;
        n_mult       = r_mult;
        n_alpha      = r_alpha;
        n_k          = r_k;
        n_rptr       = r_rptr;
        n_rd_pend    = r_rd_pend;
        n_ema_div    = r_ema_div;
        n_res        = r_res;
        n_res_valid  = r_res_valid;
        n_out_valid  = r_out_valid;
        n_avg        = r_avg;
        n_vres       = r_vres;

        // Drop the output beat once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            msa_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (w_open) begin
                        if (r_bar_cnt != '0) begin
                            n_wslot      = w_wslot_inc;
                            n_last_price = r_cur_price;
                            n_ema_prev   = r_ema_cur;
                        end
                        if (r_bar_cnt < PER_W'(msa_pkg::PERIOD_MAX)) begin
                            n_bar_cnt = r_bar_cnt + PER_W'(1);
                        end
                    end
                    n_cur_price = i_price;
                    n_p         = w_period;
                    n_meth_q    = r_method;
                    n_state     = msa_pkg::S_PREP;
                end
            end
            msa_pkg::S_PREP: begin
                if (r_bar_cnt < r_p) begin
                    n_res       = '0;
                    n_res_valid = 1'b0;
                    n_state     = msa_pkg::S_DONE;
                end else if (r_meth_q == msa_pkg::METHOD_SMA) begin
                    n_acc     = ACC_W'(r_cur_price);
                    n_k       = PER_W'(1);
                    n_rptr    = w_wslot_dec;
                    n_rd_pend = 1'b0;
                    n_state   = msa_pkg::S_SUM;
                end else begin
                    // alpha = 2.0 in Q.16 divided by (period + 1)
                    n_num     = {msa_pkg::ALPHA_NUM, {(NUM_W - ANUM_W){1'b0}}};
                    n_rem     = '0;
                    n_div     = r_p + PER_W'(1);
                    n_cnt     = STEP_W'(ANUM_W);
                    n_ema_div = 1'b1;
                    n_state   = msa_pkg::S_DIV;
                end
            end
            msa_pkg::S_SUM: begin
                // Issue one ring read per cycle, add it the cycle after
                if (r_rd_pend) begin
                    n_acc = w_alu_rsp.sum;
                end
                if (w_issue) begin
                    n_k    = r_k + PER_W'(1);
                    n_rptr = w_rptr_dec;
                end
                n_rd_pend = w_issue;
                if (!w_issue && !r_rd_pend) begin
                    n_num     = {r_acc[SUM_W-1:0], {FRAC_W{1'b0}}};
                    n_rem     = '0;
                    n_div     = r_p;
                    n_cnt     = STEP_W'(NUM_W);
                    n_ema_div = 1'b0;
                    n_state   = msa_pkg::S_DIV;
                end
            end
            msa_pkg::S_DIV: begin
                n_rem = w_alu_rsp.carry ? w_alu_rsp.sum[REM_W-1:0] : w_rem_sh;
                n_num = w_quot;
                n_cnt = r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    if (r_ema_div) begin
                        n_alpha = w_quot[ALPHA_W-1:0];
                        n_acc   = '0;
                        n_mcand = ACC_W'(r_cur_price) << FRAC_W;
                        n_mult  = w_quot[ALPHA_W-1:0];
                        n_cnt   = STEP_W'(ALPHA_W);
                        n_state = msa_pkg::S_MULA;
                    end else begin
                        n_res       = w_quot[AVG_W-1:0];
                        n_res_valid = 1'b1;
                        n_state     = msa_pkg::S_DONE;
                    end
                end
            end
            msa_pkg::S_MULA: begin
                // Accumulate alpha * price in Q.32
                n_acc   = w_mul_acc;
                n_mcand = r_mcand << 1;
                n_mult  = r_mult >> 1;
                n_cnt   = r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    n_mcand = w_base;
                    n_mult  = msa_pkg::Q_ONE - r_alpha;
                    n_cnt   = STEP_W'(ALPHA_W);
                    n_state = msa_pkg::S_MULB;
                end
            end
            msa_pkg::S_MULB: begin
                // Add (1 - alpha) * base, then truncate back to Q.16
                n_acc   = w_mul_acc;
                n_mcand = r_mcand << 1;
                n_mult  = r_mult >> 1;
                n_cnt   = r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    n_res       = w_mul_acc[ACC_W-1:FRAC_W];
                    n_res_valid = 1'b1;
                    n_state     = msa_pkg::S_DONE;
                end
            end
            msa_pkg::S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_avg       = r_res;
                    n_vres      = r_res_valid;
                    n_ema_cur   = r_res;
                    n_state     = msa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = msa_pkg::S_IDLE;
            end
        endcase
    end

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= msa_pkg::METHOD_SMA;
            r_wl     <= msa_pkg::WL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                msa_pkg::CFG_METHOD: r_method <= i_cfg_data[0];
                msa_pkg::CFG_WINDOW: r_wl     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control and bar state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= msa_pkg::S_IDLE;
            r_bar_cnt    <= '0;
            r_wslot      <= '0;
            r_cur_price  <= '0;
            r_last_price <= '0;
            r_ema_cur    <= '0;
            r_ema_prev   <= '0;
            r_rd_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_bar_cnt    <= n_bar_cnt;
            r_wslot      <= n_wslot;
            r_cur_price  <= n_cur_price;
            r_last_price <= n_last_price;
            r_ema_cur    <= n_ema_cur;
            r_ema_prev   <= n_ema_prev;
            r_rd_pend    <= n_rd_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    // Datapath payload
    always_ff @(posedge i_clk) begin
        r_p         <= n_p;
        r_meth_q    <= n_meth_q;
        r_acc       <= n_acc;
        r_num       <= n_num;
        r_rem       <= n_rem;
        r_div       <= n_div;
        r_cnt       <= n_cnt;
        r_mcand     <= n_mcand;
        r_mult      <= n_mult;
        r_alpha     <= n_alpha;
        r_k         <= n_k;
        r_rptr      <= n_rptr;
        r_ema_div   <= n_ema_div;
        r_res       <= n_res;
        r_res_valid <= n_res_valid;
        r_avg       <= n_avg;
        r_vres      <= n_vres;
    end

    a_acc_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == msa_pkg::S_PREP))
        else $error("accepted beat did not start the sequencer");

    a_bar_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bar_cnt <= PER_W'(msa_pkg::PERIOD_MAX))
        else $error("bar count beyond saturation");

    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res) |-> (o_average == '0))
        else $error("nonzero average on an invalid result");

    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msa_pkg::S_DIV) |-> (r_cnt != '0))
        else $error("divider ran out of steps");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == msa_pkg::S_DONE) && r_out_valid && i_out_stall)
            |=> (r_state == msa_pkg::S_DONE))
        else $error("result left while output register was full");

endmodule
